// ===== rtl/nmnp_pkg.sv =====
// shared types, constants and helpers of the nibble-port mouse
package nmnp_pkg;

  localparam int CW         = 32;
  localparam int TGT_W      = 32;
  localparam int CYC_W      = 48;
  localparam int DIV_W      = 11;
  localparam int STEP_W     = 8;
  localparam int TMO_W      = 16;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(TGT_W);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   wide_t;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_RISE = 2'd1;
  localparam logic [1:0] CMD_FALL = 2'd2;
  localparam logic [1:0] CMD_POT  = 2'd3;

  localparam logic [1:0] PH_X_HI = 2'd0;
  localparam logic [1:0] PH_X_LO = 2'd1;
  localparam logic [1:0] PH_Y_HI = 2'd2;
  localparam logic [1:0] PH_Y_LO = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;

  localparam logic [DIV_W-1:0]  DIVIDE_RST  = 11'd1;
  localparam logic [STEP_W-1:0] STEP_RST    = 8'd31;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd232;

  localparam logic [DATA_W-1:0] PORT_LEFT = 8'hE0;
  localparam logic [DATA_W-1:0] PORT_IDLE = 8'hF0;
  localparam logic [DATA_W-1:0] POT_ON    = 8'hFF;
  localparam logic [DATA_W-1:0] POT_OFF   = 8'h00;
  localparam logic [DATA_W-1:0] ZERO_DATA = 8'h00;

  localparam wide_t SAT_HI = (CW+1)'(127);
  localparam wide_t SAT_LO = (CW+1)'(-128);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_SIGN,
    S_DIFF,
    S_MAG,
    S_TRACK,
    S_MOVE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_load;
    logic div_step;
    logic fix_sign;
    logic diff;
    logic mag;
    logic track;
    logic move;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic need_latch;
  } stat_t;

  // clamp a signed difference to -128..127
  function automatic logic [7:0] sat8(input wide_t v);
    if (v > SAT_HI) begin
      sat8 = 8'h7F;
    end else if (v < SAT_LO) begin
      sat8 = 8'h80;
    end else begin
      sat8 = v[7:0];
    end
  endfunction

endpackage

// ===== rtl/nmnp_ifs.sv =====
// valid/ready channel interfaces: input item, result item, register writes
interface nmnp_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         cmd;
  logic [nmnp_pkg::CYC_W-1:0]         cycle_count;
  logic signed [nmnp_pkg::TGT_W-1:0]  target_x;
  logic signed [nmnp_pkg::TGT_W-1:0]  target_y;
  logic                               left_pressed;
  logic                               right_pressed;

  modport source(output valid, cmd, cycle_count, target_x, target_y, left_pressed,
                 right_pressed, input ready);
  modport sink(input valid, cmd, cycle_count, target_x, target_y, left_pressed,
               right_pressed, output ready);
endinterface

interface nmnp_out_if;
  logic                        valid;
  logic                        ready;
  logic [nmnp_pkg::DATA_W-1:0] read_data;

  modport source(output valid, read_data, input ready);
  modport sink(input valid, read_data, output ready);
endinterface

interface nmnp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nmnp_pkg::CFG_IDX_W-1:0]  index;
  logic [nmnp_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/nmnp_dp.sv =====
// datapath: registers, dividers, position tracking and port byte
module nmnp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nmnp_pkg::ctl_t                    ctl,
  input  logic [1:0]                        cmd,
  input  logic [nmnp_pkg::CYC_W-1:0]        cycle_count,
  input  logic signed [nmnp_pkg::TGT_W-1:0] target_x,
  input  logic signed [nmnp_pkg::TGT_W-1:0] target_y,
  input  logic                              left_pressed,
  input  logic                              right_pressed,
  input  logic                              cfg_we,
  input  logic [nmnp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nmnp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output nmnp_pkg::stat_t                   stat,
  output logic [nmnp_pkg::DATA_W-1:0]       read_data
);

  // captured item
  logic [1:0]                        cmd_r;
  logic [nmnp_pkg::CYC_W-1:0]        cyc_r;
  logic signed [nmnp_pkg::TGT_W-1:0] tx_r;
  logic signed [nmnp_pkg::TGT_W-1:0] ty_r;
  logic                              left_r;
  logic                              right_r;

  // configuration
  logic [nmnp_pkg::DIV_W-1:0]  div_x_r;
  logic [nmnp_pkg::DIV_W-1:0]  div_y_r;
  logic [nmnp_pkg::STEP_W-1:0] step_x_r;
  logic [nmnp_pkg::STEP_W-1:0] step_y_r;
  logic [nmnp_pkg::TMO_W-1:0]  tmo_r;

  // protocol state
  logic [1:0]                 phase_r;
  logic [1:0]                 phase_nxt;
  logic [nmnp_pkg::CYC_W-1:0] last_r;
  logic                       latch_r;
  logic                       tmo_hit;
  logic [nmnp_pkg::DATA_W-1:0] read_data_r;
  logic [nmnp_pkg::DATA_W-1:0] read_data_nxt;
  logic [1:0]                 rd_phase;
  logic [3:0]                 nibble;

  // per-axis lanes: 0 is X, 1 is Y
  logic signed [nmnp_pkg::TGT_W-1:0] tgt       [2];
  logic [nmnp_pkg::DIV_W-1:0]        dsel      [2];
  logic [nmnp_pkg::STEP_W-1:0]       stp       [2];
  logic [nmnp_pkg::DIV_W-1:0]        dvsr      [2];
  logic [nmnp_pkg::DIV_W:0]          trial     [2];
  logic                              take      [2];
  logic [nmnp_pkg::TGT_W-1:0]        dvd_r     [2];
  logic [nmnp_pkg::TGT_W-1:0]        dvd_nxt   [2];
  logic [nmnp_pkg::DIV_W-1:0]        rem_r     [2];
  logic [nmnp_pkg::DIV_W-1:0]        rem_nxt   [2];
  logic                              neg_r     [2];
  logic [nmnp_pkg::TGT_W-1:0]        mag_in    [2];
  logic signed [nmnp_pkg::TGT_W:0]   qs        [2];
  nmnp_pkg::coord_t                  q_r       [2];
  nmnp_pkg::coord_t                  q_nxt     [2];
  nmnp_pkg::wide_t                   diff_r    [2];
  nmnp_pkg::wide_t                   diff_nxt  [2];
  logic [nmnp_pkg::CW:0]             mag       [2];
  logic                              jump_r    [2];
  logic                              jump_nxt  [2];
  logic [nmnp_pkg::STEP_W-1:0]       amt_r     [2];
  logic [nmnp_pkg::STEP_W-1:0]       amt_nxt   [2];
  logic                              dneg_r    [2];
  nmnp_pkg::coord_t                  track_r   [2];
  nmnp_pkg::coord_t                  track_nxt [2];
  nmnp_pkg::coord_t                  held_r    [2];
  nmnp_pkg::wide_t                   mv_diff   [2];
  logic [7:0]                        move_r    [2];
  logic [7:0]                        move_nxt  [2];

  assign tgt[0]  = tx_r;
  assign tgt[1]  = ty_r;
  assign dsel[0] = div_x_r;
  assign dsel[1] = div_y_r;
  assign stp[0]  = step_x_r;
  assign stp[1]  = step_y_r;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r   <= cmd;
      cyc_r   <= cycle_count;
      tx_r    <= target_x;
      ty_r    <= target_y;
      left_r  <= left_pressed;
      right_r <= right_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_x_r  <= nmnp_pkg::DIVIDE_RST;
      div_y_r  <= nmnp_pkg::DIVIDE_RST;
      step_x_r <= nmnp_pkg::STEP_RST;
      step_y_r <= nmnp_pkg::STEP_RST;
      tmo_r    <= nmnp_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nmnp_pkg::REG_DIVIDE_X: div_x_r  <= cfg_data[nmnp_pkg::DIV_W-1:0];
        nmnp_pkg::REG_DIVIDE_Y: div_y_r  <= cfg_data[nmnp_pkg::DIV_W-1:0];
        nmnp_pkg::REG_STEP_X:   step_x_r <= cfg_data[nmnp_pkg::STEP_W-1:0];
        nmnp_pkg::REG_STEP_Y:   step_y_r <= cfg_data[nmnp_pkg::STEP_W-1:0];
        nmnp_pkg::REG_TIMEOUT:  tmo_r    <= cfg_data[nmnp_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // sum is one bit wider so it never wraps
  assign tmo_hit = {1'b0, cyc_r} >
                   ({1'b0, last_r} +
                    {{(nmnp_pkg::CYC_W + 1 - nmnp_pkg::TMO_W){1'b0}}, tmo_r});

  assign stat.need_latch =
      ((cmd_r == nmnp_pkg::CMD_READ) && (phase_r != nmnp_pkg::PH_X_HI) && tmo_hit) ||
      ((cmd_r == nmnp_pkg::CMD_FALL) && (phase_r == nmnp_pkg::PH_Y_LO));

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      // a zero divisor acts as one
      dvsr[i]   = (dsel[i] == '0) ? nmnp_pkg::DIV_W'(1) : dsel[i];
      mag_in[i] = tgt[i][nmnp_pkg::TGT_W-1] ? (nmnp_pkg::TGT_W)'(-tgt[i])
                                            : (nmnp_pkg::TGT_W)'(tgt[i]);
      // restoring division, one quotient bit per step
      trial[i]  = {rem_r[i], dvd_r[i][nmnp_pkg::TGT_W-1]};
      take[i]   = trial[i] >= {1'b0, dvsr[i]};
      rem_nxt[i] = take[i] ? nmnp_pkg::DIV_W'(trial[i] - {1'b0, dvsr[i]})
                           : trial[i][nmnp_pkg::DIV_W-1:0];
      dvd_nxt[i] = {dvd_r[i][nmnp_pkg::TGT_W-2:0], take[i]};

      qs[i]    = neg_r[i] ? -$signed({1'b0, dvd_r[i]}) : $signed({1'b0, dvd_r[i]});
      q_nxt[i] = nmnp_pkg::coord_t'(qs[i]);

      diff_nxt[i] = $signed({q_r[i][nmnp_pkg::CW-1], q_r[i]}) -
                    $signed({track_r[i][nmnp_pkg::CW-1], track_r[i]});

      mag[i] = diff_r[i][nmnp_pkg::CW] ? (nmnp_pkg::CW+1)'(-diff_r[i])
                                       : (nmnp_pkg::CW+1)'(diff_r[i]);
      jump_nxt[i] = (mag[i] >> 3) > (nmnp_pkg::CW+1)'(stp[i]);
      amt_nxt[i]  = (mag[i] < (nmnp_pkg::CW+1)'(stp[i])) ? mag[i][nmnp_pkg::STEP_W-1:0]
                                                         : stp[i];

      if (jump_r[i]) begin
        track_nxt[i] = q_r[i];
      end else if (dneg_r[i]) begin
        track_nxt[i] = track_r[i] - nmnp_pkg::coord_t'(amt_r[i]);
      end else begin
        track_nxt[i] = track_r[i] + nmnp_pkg::coord_t'(amt_r[i]);
      end

      // X reports held minus track, Y reports track minus held
      if (i == 0) begin
        mv_diff[i] = $signed({held_r[i][nmnp_pkg::CW-1], held_r[i]}) -
                     $signed({track_r[i][nmnp_pkg::CW-1], track_r[i]});
      end else begin
        mv_diff[i] = $signed({track_r[i][nmnp_pkg::CW-1], track_r[i]}) -
                     $signed({held_r[i][nmnp_pkg::CW-1], held_r[i]});
      end
      move_nxt[i] = nmnp_pkg::sat8(mv_diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (ctl.div_load) begin
        dvd_r[i] <= mag_in[i];
        rem_r[i] <= '0;
        neg_r[i] <= tgt[i][nmnp_pkg::TGT_W-1];
      end else if (ctl.div_step) begin
        dvd_r[i] <= dvd_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
      if (ctl.fix_sign) begin
        q_r[i] <= q_nxt[i];
      end
      if (ctl.diff) begin
        diff_r[i] <= diff_nxt[i];
      end
      if (ctl.mag) begin
        jump_r[i] <= jump_nxt[i];
        amt_r[i]  <= amt_nxt[i];
        dneg_r[i] <= diff_r[i][nmnp_pkg::CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        track_r[i] <= '0;
        held_r[i]  <= '0;
        move_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        if (ctl.track) begin
          track_r[i] <= track_nxt[i];
        end
        if (ctl.move) begin
          move_r[i] <= move_nxt[i];
          held_r[i] <= track_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      latch_r <= stat.need_latch;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (cmd_r)
      nmnp_pkg::CMD_READ: begin
        if (latch_r) begin
          phase_nxt = nmnp_pkg::PH_X_HI;
        end
      end
      nmnp_pkg::CMD_RISE: begin
        if (phase_r == nmnp_pkg::PH_X_HI) begin
          phase_nxt = nmnp_pkg::PH_X_LO;
        end else if (phase_r == nmnp_pkg::PH_Y_HI) begin
          phase_nxt = nmnp_pkg::PH_Y_LO;
        end
      end
      nmnp_pkg::CMD_FALL: begin
        if (phase_r == nmnp_pkg::PH_X_LO) begin
          phase_nxt = nmnp_pkg::PH_Y_HI;
        end else if (phase_r == nmnp_pkg::PH_Y_LO) begin
          phase_nxt = nmnp_pkg::PH_X_HI;
        end
      end
      default: ;
    endcase
  end

  assign rd_phase = phase_nxt;

  always_comb begin
    unique case (rd_phase)
      nmnp_pkg::PH_X_HI: nibble = move_r[0][7:4];
      nmnp_pkg::PH_X_LO: nibble = move_r[0][3:0];
      nmnp_pkg::PH_Y_HI: nibble = move_r[1][7:4];
      default:           nibble = move_r[1][3:0];
    endcase
  end

  always_comb begin
    unique case (cmd_r)
      nmnp_pkg::CMD_READ:
        read_data_nxt = (left_r ? nmnp_pkg::PORT_LEFT : nmnp_pkg::PORT_IDLE) |
                        {4'h0, nibble};
      nmnp_pkg::CMD_POT:
        read_data_nxt = right_r ? nmnp_pkg::POT_ON : nmnp_pkg::POT_OFF;
      default:
        read_data_nxt = nmnp_pkg::ZERO_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nmnp_pkg::PH_X_HI;
      last_r  <= '0;
    end else if (ctl.commit) begin
      phase_r <= phase_nxt;
      if ((cmd_r == nmnp_pkg::CMD_RISE) || (cmd_r == nmnp_pkg::CMD_FALL)) begin
        last_r <= cyc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      read_data_r <= read_data_nxt;
    end
  end

  assign read_data = read_data_r;

endmodule

// ===== rtl/nmnp_ctrl.sv =====
// controller: sequences accept, divide, track and result hand-off
module nmnp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  input  nmnp_pkg::stat_t stat,
  output nmnp_pkg::ctl_t  ctl,
  output logic            in_ready,
  output logic            out_valid
);

  nmnp_pkg::state_t                state_r;
  nmnp_pkg::state_t                state_nxt;
  logic [nmnp_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [nmnp_pkg::DIV_CNT_W-1:0]  cnt_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            slot_free;
  logic                            div_last;

  assign slot_free = !out_valid_r || out_ready;
  assign div_last  = cnt_r == nmnp_pkg::DIV_CNT_W'(nmnp_pkg::TGT_W - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nmnp_pkg::S_IDLE:  if (in_valid) state_nxt = nmnp_pkg::S_EVAL;
      nmnp_pkg::S_EVAL:  state_nxt = stat.need_latch ? nmnp_pkg::S_DIV : nmnp_pkg::S_OUT;
      nmnp_pkg::S_DIV:   if (div_last) state_nxt = nmnp_pkg::S_SIGN;
      nmnp_pkg::S_SIGN:  state_nxt = nmnp_pkg::S_DIFF;
      nmnp_pkg::S_DIFF:  state_nxt = nmnp_pkg::S_MAG;
      nmnp_pkg::S_MAG:   state_nxt = nmnp_pkg::S_TRACK;
      nmnp_pkg::S_TRACK: state_nxt = nmnp_pkg::S_MOVE;
      nmnp_pkg::S_MOVE:  state_nxt = nmnp_pkg::S_OUT;
      nmnp_pkg::S_OUT:   if (slot_free) state_nxt = nmnp_pkg::S_IDLE;
      default:           state_nxt = nmnp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      nmnp_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        ctl.load_in = in_valid;
      end
      nmnp_pkg::S_EVAL: begin
        ctl.eval     = 1'b1;
        ctl.div_load = stat.need_latch;
      end
      nmnp_pkg::S_DIV:   ctl.div_step = 1'b1;
      nmnp_pkg::S_SIGN:  ctl.fix_sign = 1'b1;
      nmnp_pkg::S_DIFF:  ctl.diff     = 1'b1;
      nmnp_pkg::S_MAG:   ctl.mag      = 1'b1;
      nmnp_pkg::S_TRACK: ctl.track    = 1'b1;
      nmnp_pkg::S_MOVE:  ctl.move     = 1'b1;
      nmnp_pkg::S_OUT:   ctl.commit   = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.div_load) begin
      cnt_nxt = '0;
    end else if (ctl.div_step) begin
      cnt_nxt = cnt_r + nmnp_pkg::DIV_CNT_W'(1);
    end
  end

  // a new item may replace the one being taken in the same cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nmnp_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/neos_mouse_nibble_port_top.sv =====
// Strobe-clocked mouse port: each input item is a port read, a rising or falling strobe
// or a pot read, and yields exactly one result item with the byte read (zero for strobes).
// Items are handled one at a time. An item that does not latch a new position goes from
// accept through evaluation to the result; one that latches (the falling strobe ending
// the Y low nibble, or a port read after the strobe timeout outside the X high nibble)
// first passes the 32-step restoring divider that produces one quotient bit per cycle
// for X and Y side by side, then five tracking steps. The input is taken again the cycle
// after the result is loaded into the output register, even if it is still waiting.
// Register writes are taken in every cycle and should be made only while no item is open.
module neos_mouse_nibble_port_top (
  input logic          clk,
  input logic          rst_n,
  nmnp_in_if.sink      in_ch,
  nmnp_out_if.source   out_ch,
  nmnp_cfg_if.sink     cfg_ch
);

  nmnp_pkg::ctl_t  ctl;
  nmnp_pkg::stat_t stat;
  logic            in_acc;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  nmnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  nmnp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cmd           (in_ch.cmd),
    .cycle_count   (in_ch.cycle_count),
    .target_x      (in_ch.target_x),
    .target_y      (in_ch.target_y),
    .left_pressed  (in_ch.left_pressed),
    .right_pressed (in_ch.right_pressed),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .stat          (stat),
    .read_data     (out_ch.read_data)
  );

  a_accept_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ctl.eval)
    else $error("accepted item not evaluated next cycle");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending item");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_ch.valid)
    else $error("loaded result not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.div_step || ctl.track || ctl.move) |-> !in_ch.ready)
    else $error("input ready while an item is in the divider or tracker");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench of the nibble-port mouse: directed and random port accesses checked by a predictor
module tb_top;
  import nmnp_pkg::*;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 255;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [1:0]              cmd;
    logic [CYC_W-1:0]        cyc;
    logic signed [TGT_W-1:0] tx;
    logic signed [TGT_W-1:0] ty;
    logic                    left;
    logic                    right;
  } access_t;

  logic clk = 1'b0;
  logic rst_n;

  nmnp_in_if  in_ch();
  nmnp_out_if out_ch();
  nmnp_cfg_if cfg_ch();

  neos_mouse_nibble_port_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #4 clk = ~clk;

  // predictor copy of registers and state
  logic [DIV_W-1:0]  m_div_x, m_div_y;
  logic [STEP_W-1:0] m_step_x, m_step_y;
  logic [TMO_W-1:0]  m_timeout;
  logic [1:0]        m_phase;
  logic [CYC_W-1:0]  m_last_strobe;
  longint            m_track_x, m_track_y, m_held_x, m_held_y;
  logic [7:0]        m_move_x, m_move_y;

  access_t    pending_accesses[$];
  logic [7:0] due_bytes[$];
  access_t    on_bus;
  logic [7:0] want;
  int n_issued = 0;
  int n_taken = 0;
  int n_errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;
  int unsigned n_cycles = 0;

  // stimulus generator state
  logic [CYC_W-1:0] g_stamp;
  longint           g_tx, g_ty;

  function automatic longint follow(longint pos, longint tgt, logic [DIV_W-1:0] dv,
                                    logic [STEP_W-1:0] st);
    longint d, q, s, delta;
    d = (dv == '0) ? 64'sd1 : longint'(dv);
    q = longint'(coord_t'(tgt / d));
    s = longint'(st);
    delta = q - pos;
    if (delta < 0) delta = -delta;
    if (delta / 8 > s) pos = q;
    if (q < pos) begin
      pos -= (pos - q < s) ? pos - q : s;
    end else if (q > pos) begin
      pos += (q - pos < s) ? q - pos : s;
    end
    return pos;
  endfunction

  function automatic logic [7:0] clamp8(longint v);
    if (v > 127) return 8'h7F;
    if (v < -128) return 8'h80;
    return v[7:0];
  endfunction

  function automatic void take_position(longint tx, longint ty);
    m_track_x = follow(m_track_x, tx, m_div_x, m_step_x);
    m_track_y = follow(m_track_y, ty, m_div_y, m_step_y);
    m_move_x = clamp8(m_held_x - m_track_x);
    m_move_y = clamp8(m_track_y - m_held_y);
    m_held_x = m_track_x;
    m_held_y = m_track_y;
  endfunction

  function automatic logic [7:0] mouse_read(access_t a);
    logic [7:0] r;
    r = ZERO_DATA;
    case (a.cmd)
      CMD_READ: begin
        r = a.left ? PORT_LEFT : PORT_IDLE;
        // late read: sequence restarts with a fresh position
        if (m_phase != PH_X_HI && {1'b0, a.cyc} > {1'b0, m_last_strobe} + m_timeout) begin
          m_phase = PH_X_HI;
          take_position(longint'(a.tx), longint'(a.ty));
        end
        case (m_phase)
          PH_X_HI: r = r | {4'h0, m_move_x[7:4]};
          PH_X_LO: r = r | {4'h0, m_move_x[3:0]};
          PH_Y_HI: r = r | {4'h0, m_move_y[7:4]};
          default: r = r | {4'h0, m_move_y[3:0]};
        endcase
      end
      CMD_RISE: begin
        if (m_phase == PH_X_HI) m_phase = PH_X_LO;
        else if (m_phase == PH_Y_HI) m_phase = PH_Y_LO;
        m_last_strobe = a.cyc;
      end
      CMD_FALL: begin
        if (m_phase == PH_X_LO) begin
          m_phase = PH_Y_HI;
        end else if (m_phase == PH_Y_LO) begin
          m_phase = PH_X_HI;
          take_position(longint'(a.tx), longint'(a.ty));
        end
        m_last_strobe = a.cyc;
      end
      default: r = a.right ? POT_ON : POT_OFF;
    endcase
    return r;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DIVIDE_X: m_div_x = val[DIV_W-1:0];
      REG_DIVIDE_Y: m_div_y = val[DIV_W-1:0];
      REG_STEP_X:   m_step_x = val[STEP_W-1:0];
      REG_STEP_Y:   m_step_y = val[STEP_W-1:0];
      REG_TIMEOUT:  m_timeout = val[TMO_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic void add_access(logic [1:0] cmd, logic [CYC_W-1:0] cyc,
                                     logic signed [TGT_W-1:0] tx, logic signed [TGT_W-1:0] ty,
                                     logic left, logic right);
    access_t a;
    a.cmd = cmd;
    a.cyc = cyc;
    a.tx = tx;
    a.ty = ty;
    a.left = left;
    a.right = right;
    pending_accesses.push_back(a);
    n_issued++;
  endfunction

  function automatic logic [CYC_W-1:0] short_stride();
    int unsigned lim;
    lim = (m_timeout > 4) ? m_timeout / 4 : 1;
    return CYC_W'($urandom_range(1, lim));
  endfunction

  // new target near the current one, so that both steps and jumps occur
  function automatic longint walk(longint cur, logic [DIV_W-1:0] dv, logic [STEP_W-1:0] st);
    longint span, d;
    if ($urandom_range(0, 9) == 0) return longint'($signed($urandom()));
    d = (dv == '0) ? 64'sd1 : longint'(dv);
    span = d * (longint'(st) + 1) * longint'($urandom_range(1, 12));
    return longint'(coord_t'(cur + longint'($urandom_range(0, 2 * span)) - span));
  endfunction

  function automatic void emit(logic [1:0] cmd, logic [CYC_W-1:0] stride);
    g_stamp += stride;
    add_access(cmd, g_stamp, g_tx[TGT_W-1:0], g_ty[TGT_W-1:0],
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // one full X/Y report, pot reads sprinkled in
  function automatic int gen_frame();
    int n;
    logic [1:0] cmd;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        emit(CMD_POT, short_stride());
        n++;
      end
      case (k)
        1, 5:    cmd = CMD_RISE;
        3, 7:    cmd = CMD_FALL;
        default: cmd = CMD_READ;
      endcase
      if (k == 7) begin
        g_tx = walk(g_tx, m_div_x, m_step_x);
        g_ty = walk(g_ty, m_div_y, m_step_y);
      end
      emit(cmd, short_stride());
      n++;
    end
    return n;
  endfunction

  function automatic void gen_phase(int n_items);
    int n, kind, burst;
    logic [CYC_W-1:0] stride;
    n = 0;
    while (n < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        n += gen_frame();
      end else if (kind < 17) begin
        // read right at or just past the timeout
        emit(CMD_RISE, short_stride());
        g_tx = walk(g_tx, m_div_x, m_step_x);
        g_ty = walk(g_ty, m_div_y, m_step_y);
        emit(CMD_READ, CYC_W'(m_timeout) + CYC_W'($urandom_range(0, 2)));
        n += 2;
      end else begin
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 7) == 0) stride = CYC_W'({$urandom(), $urandom()});
          else stride = short_stride();
          if ($urandom_range(0, 3) == 0) begin
            g_tx = longint'($signed($urandom()));
            g_ty = longint'($signed($urandom()));
          end
          emit(2'($urandom_range(0, 3)), stride);
          n++;
        end
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    set_reg(idx, val);
  endtask

  task automatic settle();
    while (n_taken != n_issued || due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_bytes.push_back(mouse_read(on_bus));
        n_taken++;
        in_gap = pick_gap(in_calm);
        if ($urandom_range(0, 59) == 0) in_calm = !in_calm;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          on_bus = pending_accesses.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= on_bus.cmd;
          in_ch.cycle_count <= on_bus.cyc;
          in_ch.target_x <= on_bus.tx;
          in_ch.target_y <= on_bus.ty;
          in_ch.left_pressed <= on_bus.left;
          in_ch.right_pressed <= on_bus.right;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_bytes.size() == 0) begin
          $error("read_data %02h arrived with nothing expected", out_ch.read_data);
          n_errors++;
        end else begin
          want = due_bytes.pop_front();
          if (out_ch.read_data !== want) begin
            $error("read_data mismatch: expected %02h, got %02h", want, out_ch.read_data);
            n_errors++;
          end
        end
        out_gap = pick_gap(out_calm);
        if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ch.ready <= (out_gap == 0) && (hold_cnt == 0);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] dx, dy, sx, sy, tm;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_READ;
    in_ch.cycle_count = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.left_pressed = 1'b0;
    in_ch.right_pressed = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DIVIDE_X;
    cfg_ch.data = '0;
    m_div_x = DIVIDE_RST;
    m_div_y = DIVIDE_RST;
    m_step_x = STEP_RST;
    m_step_y = STEP_RST;
    m_timeout = TIMEOUT_RST;
    m_phase = PH_X_HI;
    m_last_strobe = '0;
    m_track_x = 0;
    m_track_y = 0;
    m_held_x = 0;
    m_held_y = 0;
    m_move_x = '0;
    m_move_y = '0;
    g_stamp = '0;
    g_tx = 0;
    g_ty = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on reset settings
    add_access(CMD_POT, 48'd10, 32'sd0, 32'sd0, 1'b0, 1'b1);
    add_access(CMD_POT, 48'd11, 32'sd0, 32'sd0, 1'b1, 1'b0);
    add_access(CMD_READ, 48'd12, 32'sd0, 32'sd0, 1'b1, 1'b0);
    add_access(CMD_READ, 48'd13, 32'sd0, 32'sd0, 1'b0, 1'b0);
    // strobes that do not fit the phase only record the stamp
    add_access(CMD_FALL, 48'd20, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_RISE, 48'd30, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_RISE, 48'd31, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd32, 32'sd0, 32'sd0, 1'b1, 1'b1);
    add_access(CMD_FALL, 48'd40, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_FALL, 48'd41, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd42, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_RISE, 48'd50, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd51, 32'sd0, 32'sd0, 1'b1, 1'b0);
    add_access(CMD_FALL, 48'd52, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd53, 32'sd0, 32'sd0, 1'b0, 1'b0);
    // timeout edge: equal stamp keeps the phase, one more restarts it
    add_access(CMD_RISE, 48'd1000, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd1232, 32'sd5, 32'sd5, 1'b1, 1'b0);
    add_access(CMD_READ, 48'd1233, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
    // stamp near the top: timeout sum must not wrap
    add_access(CMD_RISE, 48'hFFFF_FFFF_FFF0, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_READ, 48'hFFFF_FFFF_FFFF, 32'sd0, 32'sd0, 1'b0, 1'b1);
    add_access(CMD_READ, 48'd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    add_access(CMD_FALL, 48'd5, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_RISE, 48'd6, 32'sd0, 32'sd0, 1'b0, 1'b0);
    add_access(CMD_FALL, 48'd7, 32'h8000_0064, 32'h7FFF_FF9B, 1'b0, 1'b0);
    add_access(CMD_READ, 48'd8, 32'sd0, 32'sd0, 1'b0, 1'b0);
    settle();
    g_stamp = m_last_strobe;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          dx = 16'd1; dy = 16'd1; sx = 16'd255; sy = 16'd255; tm = 16'hFFFF;
        end
        1: begin
          // zero divisor acts as one, zero step moves only by jumps
          dx = 16'd0; dy = 16'd0; sx = 16'd0; sy = 16'd0; tm = 16'd0;
        end
        2: begin
          // upper data bits beyond the register width are dropped
          dx = 16'hFFFF; dy = 16'd1024; sx = 16'd1; sy = 16'h0301; tm = 16'd1;
        end
        default: begin
          dx = 16'($urandom_range(1, 1024));
          dy = 16'($urandom_range(1, 1024));
          sx = 16'($urandom_range(1, 255));
          sy = 16'($urandom_range(1, 255));
          tm = 16'($urandom_range(1, 400));
        end
      endcase
      write_reg(REG_DIVIDE_X, dx);
      write_reg(REG_DIVIDE_Y, dy);
      write_reg(REG_STEP_X, sx);
      write_reg(REG_STEP_Y, sy);
      write_reg(REG_TIMEOUT, tm);
      if (p == 1) write_reg(REG_UNUSED, 16'($urandom()));
      cfg_ch.valid <= 1'b0;
      gen_phase(PHASE_ITEMS);
      if (p == 0 || p == 3) hold_req <= !hold_req;
      settle();
    end

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
